// ----- rtl/bpa_pkg.sv -----
// Shared types, constants and helper functions for the buddy page allocator.
// Used by bpa_lists and buddy_page_allocator; has no dependencies of its own.
package bpa_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int NUM_ORDERS = 11;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int LINK_W     = PAGE_W + 1;
    localparam int ORD_W      = $clog2(NUM_ORDERS);
    localparam int OCALC_W    = 5;
    localparam int CNT_W      = 13;
    localparam int MEM_W      = 1 + ORD_W + 2 * LINK_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [ORD_W-1:0]   ord_t;
    typedef logic [OCALC_W-1:0] ocalc_t;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH,
        S_A_SCAN, S_A_SPLIT, S_A_MARK,
        S_F_HEAD, S_F_LOOP, S_F_BUD, S_F_MERGE,
        S_R_LOOP, S_R_HEAD, S_R_NEXT,
        S_P_WR, S_P_FIX,
        S_D_RD, S_D_GOT, S_D_FIXP, S_D_FIXN,
        S_DONE
    } state_t;

    // Input transaction.
    typedef struct packed {
        logic [1:0]       operation;
        logic [11:0]      page;
        logic [CNT_W-1:0] count;
    } bpa_req_t;

    // Result transaction.
    typedef struct packed {
        logic [1:0]       status;
        logic [11:0]      block_page;
        logic [CNT_W-1:0] free_total;
    } bpa_rsp_t;

    // One word of the per-page memory.
    typedef struct packed {
        logic  head;
        ord_t  ord;
        link_t nxt;
        link_t prv;
    } meta_t;

    // Update command for the free-list table.
    typedef struct packed {
        logic  inc;
        logic  dec;
        logic  wr_front;
        ord_t  ord;
        link_t front;
    } lst_cmd_t;

    // Smallest order whose block holds cnt pages; zero counts as one page.
    function automatic ocalc_t order_of(input logic [CNT_W-1:0] cnt);
        ocalc_t o;
        o = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if ((CNT_W'(1) << i) < cnt) begin
                o = OCALC_W'(i + 1);
            end
        end
        return o;
    endfunction

    // Largest aligned block at cur that fits in rem pages.
    function automatic ord_t region_order(input link_t cur, input link_t rem);
        ord_t o;
        o = '0;
        for (int i = 1; i < NUM_ORDERS; i++) begin
            if ((LINK_W'(1) << i) <= rem &&
                (cur & ((LINK_W'(1) << i) - LINK_W'(1))) == '0) begin
                o = ORD_W'(i);
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/bpa_ram.sv -----
// Generic synchronous RAM, one write and one read port, registered read data.
// A read of the address written in the same cycle returns the new data.
module bpa_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and forwarded read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && waddr == raddr)
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bpa_lists.sv -----
// Free-list table: front of each order's list, block counts and free page total.
// Depends on bpa_pkg for the command struct and sizes.
module bpa_lists (
    input  logic              clk,
    input  logic              rst_n,
    input  bpa_pkg::lst_cmd_t cmd,
    input  bpa_pkg::ord_t     rd_ord,
    output bpa_pkg::link_t    rd_front,
    output logic              rd_nonempty,
    output bpa_pkg::link_t    free_total
);
    import bpa_pkg::*;

    link_t front_reg [NUM_ORDERS];
    link_t front_next [NUM_ORDERS];
    link_t cnt_reg [NUM_ORDERS];
    link_t cnt_next [NUM_ORDERS];
    link_t free_reg;
    link_t free_next;
    link_t blk_size;
    logic  ord_ok;

    assign ord_ok   = cmd.ord < ORD_W'(NUM_ORDERS);
    assign blk_size = LINK_W'(1) << cmd.ord;

    // Apply push and drop updates.
    always_comb
    begin
        front_next = front_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        if (ord_ok)
        begin
            if (cmd.wr_front)
            begin
                front_next[cmd.ord] = cmd.front;
            end
            if (cmd.inc)
            begin
                cnt_next[cmd.ord] = cnt_reg[cmd.ord] + LINK_W'(1);
                free_next         = free_reg + blk_size;
            end
            else if (cmd.dec)
            begin
                cnt_next[cmd.ord] = cnt_reg[cmd.ord] - LINK_W'(1);
                free_next         = free_reg - blk_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                front_reg[i] <= NULL_LINK;
                cnt_reg[i]   <= '0;
            end
            free_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
            free_reg  <= free_next;
        end
    end

    // Read side for the sequencer.
    always_comb
    begin
        if (rd_ord < ORD_W'(NUM_ORDERS))
        begin
            rd_front    = front_reg[rd_ord];
            rd_nonempty = cnt_reg[rd_ord] != '0;
        end
        else
        begin
            rd_front    = NULL_LINK;
            rd_nonempty = 1'b0;
        end
    end

    assign free_total = free_reg;

endmodule

// ----- rtl/buddy_page_allocator.sv -----
// Buddy page allocator top level: sequencer over the per-page memory.
// Depends on bpa_pkg, bpa_ram and bpa_lists.
//
//  channel   signals                     direction  handshake
//  request   start, request, busy        in         accepted when start and not busy
//  result    done, result                out        one-cycle strobe, no back-pressure
//
// Each list push writes the new head and, when the list was not empty, fixes the old
// front's back link; each drop reads the links, clears the head flag and fixes each
// neighbor that exists. After reset a clearing pass zeroes the page memory; busy is high.
// The result strobe cannot be held off; busy stays high until it has been shown.
module buddy_page_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bpa_pkg::bpa_req_t request,
    output logic              busy,
    output logic              done,
    output bpa_pkg::bpa_rsp_t result
);
    import bpa_pkg::*;

    state_t   state_reg, state_next;
    state_t   ret_reg, ret_next;
    bpa_req_t req_reg, req_next;
    ocalc_t   o_reg, o_next;
    ocalc_t   want_reg, want_next;
    page_t    blk_reg, blk_next;
    link_t    cur_reg, cur_next;
    link_t    end_reg, end_next;
    ord_t     pord_reg, pord_next;
    page_t    ppg_reg, ppg_next;
    link_t    n_reg, n_next;
    link_t    p_reg, p_next;
    link_t    f_reg, f_next;
    status_t  status_reg, status_next;
    page_t    bpage_reg, bpage_next;
    page_t    clr_reg, clr_next;

    logic     ram_we;
    page_t    ram_waddr;
    meta_t    ram_wdata;
    page_t    ram_raddr;
    meta_t    ram_rdata;
    lst_cmd_t lst_cmd;
    ord_t     rd_ord;
    link_t    rd_front;
    logic     rd_nonempty;
    link_t    free_total;

    ocalc_t            ord_calc;
    logic [LINK_W:0]   free_end;
    logic [LINK_W:0]   add_end;
    link_t             bud;
    link_t             rem;
    ord_t              reg_ord;

    bpa_ram #(
        .DATA_W (MEM_W),
        .ADDR_W (PAGE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpa_lists u_lists (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (lst_cmd),
        .rd_ord      (rd_ord),
        .rd_front    (rd_front),
        .rd_nonempty (rd_nonempty),
        .free_total  (free_total)
    );

    // Shared arithmetic for the sequencer.
    assign ord_calc = order_of(req_reg.count);
    assign free_end = (LINK_W+1)'(req_reg.page) + ((LINK_W+1)'(1) << ord_calc);
    assign add_end  = (LINK_W+1)'(req_reg.page) + (LINK_W+1)'(req_reg.count);
    assign bud      = cur_reg ^ (LINK_W'(1) << o_reg);
    assign rem      = end_reg - cur_reg;
    assign reg_ord  = region_order(cur_reg, rem);

    // Next state and datapath registers.
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        req_next    = req_reg;
        o_next      = o_reg;
        want_next   = want_reg;
        blk_next    = blk_reg;
        cur_next    = cur_reg;
        end_next    = end_reg;
        pord_next   = pord_reg;
        ppg_next    = ppg_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        f_next      = f_reg;
        status_next = status_reg;
        bpage_next  = bpage_reg;
        clr_next    = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + PAGE_W'(1);
                if (clr_reg == PAGE_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                status_next = ST_OK;
                bpage_next  = '0;
                case (op_t'(req_reg.operation))
                    OP_ALLOC:
                    begin
                        want_next = ord_calc;
                        o_next    = ord_calc;
                        if (ord_calc >= OCALC_W'(NUM_ORDERS))
                        begin
                            status_next = ST_NOSPACE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_SCAN;
                        end
                    end
                    OP_FREE:
                    begin
                        o_next   = ord_calc;
                        cur_next = LINK_W'(req_reg.page);
                        if (ord_calc >= OCALC_W'(NUM_ORDERS) ||
                            free_end > (LINK_W+1)'(NUM_PAGES))
                        begin
                            status_next = ST_REJECT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_F_HEAD;
                        end
                    end
                    OP_ADD:
                    begin
                        cur_next   = LINK_W'(req_reg.page);
                        end_next   = (add_end > (LINK_W+1)'(NUM_PAGES)) ?
                                     NULL_LINK : add_end[LINK_W-1:0];
                        state_next = S_R_LOOP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            // Look for the smallest non-empty order that fits.
            S_A_SCAN:
            begin
                if (o_reg >= OCALC_W'(NUM_ORDERS))
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else if (rd_nonempty)
                begin
                    blk_next   = rd_front[PAGE_W-1:0];
                    pord_next  = o_reg[ORD_W-1:0];
                    ppg_next   = rd_front[PAGE_W-1:0];
                    ret_next   = S_A_SPLIT;
                    state_next = S_D_RD;
                end
                else
                begin
                    o_next = o_reg + OCALC_W'(1);
                end
            end
            // Halve the block, pushing each upper half.
            S_A_SPLIT:
            begin
                if (o_reg > want_reg)
                begin
                    o_next     = o_reg - OCALC_W'(1);
                    pord_next  = ORD_W'(o_reg - OCALC_W'(1));
                    ppg_next   = blk_reg + (PAGE_W'(1) << (o_reg - OCALC_W'(1)));
                    ret_next   = S_A_SPLIT;
                    state_next = S_P_WR;
                end
                else
                begin
                    state_next = S_A_MARK;
                end
            end
            S_A_MARK:
            begin
                bpage_next = blk_reg;
                state_next = S_DONE;
            end
            // Freeing a page that already heads a free block does nothing.
            S_F_HEAD:
            begin
                state_next = ram_rdata.head ? S_DONE : S_F_LOOP;
            end
            S_F_LOOP:
            begin
                if ((OCALC_W+1)'(o_reg) + (OCALC_W+1)'(1) < (OCALC_W+1)'(NUM_ORDERS) &&
                    bud < NULL_LINK)
                begin
                    ppg_next   = bud[PAGE_W-1:0];
                    state_next = S_F_BUD;
                end
                else
                begin
                    pord_next  = o_reg[ORD_W-1:0];
                    ppg_next   = cur_reg[PAGE_W-1:0];
                    ret_next   = S_DONE;
                    state_next = S_P_WR;
                end
            end
            S_F_BUD:
            begin
                pord_next = o_reg[ORD_W-1:0];
                if (!ram_rdata.head || ram_rdata.ord != o_reg[ORD_W-1:0])
                begin
                    ppg_next   = cur_reg[PAGE_W-1:0];
                    ret_next   = S_DONE;
                    state_next = S_P_WR;
                end
                else
                begin
                    ret_next   = S_F_MERGE;
                    state_next = S_D_RD;
                end
            end
            S_F_MERGE:
            begin
                if (LINK_W'(ppg_reg) < cur_reg)
                begin
                    cur_next = LINK_W'(ppg_reg);
                end
                o_next     = o_reg + OCALC_W'(1);
                state_next = S_F_LOOP;
            end
            // Carve the region into aligned blocks.
            S_R_LOOP:
            begin
                if (cur_reg >= end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    o_next     = OCALC_W'(reg_ord);
                    state_next = S_R_HEAD;
                end
            end
            S_R_HEAD:
            begin
                if (!ram_rdata.head)
                begin
                    pord_next  = o_reg[ORD_W-1:0];
                    ppg_next   = cur_reg[PAGE_W-1:0];
                    ret_next   = S_R_NEXT;
                    state_next = S_P_WR;
                end
                else
                begin
                    state_next = S_R_NEXT;
                end
            end
            S_R_NEXT:
            begin
                cur_next   = cur_reg + (LINK_W'(1) << o_reg);
                state_next = S_R_LOOP;
            end
            // Push: write the new head, then fix the old front's back link.
            S_P_WR:
            begin
                f_next     = rd_front;
                state_next = (rd_front != NULL_LINK) ? S_P_FIX : ret_reg;
            end
            S_P_FIX:
            begin
                state_next = ret_reg;
            end
            // Drop: read the links, then fix each neighbor that exists.
            S_D_RD:
            begin
                state_next = S_D_GOT;
            end
            S_D_GOT:
            begin
                n_next = ram_rdata.nxt;
                p_next = ram_rdata.prv;
                if (ram_rdata.prv != NULL_LINK)
                begin
                    state_next = S_D_FIXP;
                end
                else if (ram_rdata.nxt != NULL_LINK)
                begin
                    state_next = S_D_FIXN;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_D_FIXP:
            begin
                state_next = (n_reg != NULL_LINK) ? S_D_FIXN : ret_reg;
            end
            S_D_FIXN:
            begin
                state_next = ret_reg;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory, list table and port outputs.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ppg_reg;
        ram_wdata = ram_rdata;
        ram_raddr = ppg_reg;
        lst_cmd   = '0;
        lst_cmd.ord = pord_reg;
        rd_ord    = (state_reg == S_A_SCAN) ? o_reg[ORD_W-1:0] : pord_reg;
        busy      = state_reg != S_IDLE;
        done      = state_reg == S_DONE;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_DISPATCH:
            begin
                ram_raddr = req_reg.page;
            end
            // Fetch the allocated block's word so only its order is rewritten.
            S_A_SPLIT:
            begin
                ram_raddr = blk_reg;
            end
            S_A_MARK:
            begin
                ram_we        = 1'b1;
                ram_waddr     = blk_reg;
                ram_wdata     = ram_rdata;
                ram_wdata.ord = want_reg[ORD_W-1:0];
            end
            S_F_LOOP:
            begin
                ram_raddr = bud[PAGE_W-1:0];
            end
            S_R_LOOP:
            begin
                ram_raddr = cur_reg[PAGE_W-1:0];
            end
            S_P_WR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = ppg_reg;
                ram_wdata        = '{head: 1'b1, ord: pord_reg, nxt: rd_front, prv: NULL_LINK};
                ram_raddr        = rd_front[PAGE_W-1:0];
                lst_cmd.inc      = 1'b1;
                lst_cmd.wr_front = 1'b1;
                lst_cmd.front    = LINK_W'(ppg_reg);
            end
            S_P_FIX:
            begin
                ram_we        = 1'b1;
                ram_waddr     = f_reg[PAGE_W-1:0];
                ram_wdata     = ram_rdata;
                ram_wdata.prv = LINK_W'(ppg_reg);
            end
            S_D_RD:
            begin
                ram_raddr = ppg_reg;
            end
            S_D_GOT:
            begin
                ram_we         = 1'b1;
                ram_waddr      = ppg_reg;
                ram_wdata      = ram_rdata;
                ram_wdata.head = 1'b0;
                lst_cmd.dec    = 1'b1;
                if (ram_rdata.prv != NULL_LINK)
                begin
                    ram_raddr = ram_rdata.prv[PAGE_W-1:0];
                end
                else
                begin
                    lst_cmd.wr_front = 1'b1;
                    lst_cmd.front    = ram_rdata.nxt;
                    ram_raddr        = ram_rdata.nxt[PAGE_W-1:0];
                end
            end
            S_D_FIXP:
            begin
                ram_we        = 1'b1;
                ram_waddr     = p_reg[PAGE_W-1:0];
                ram_wdata     = ram_rdata;
                ram_wdata.nxt = n_reg;
                ram_raddr     = n_reg[PAGE_W-1:0];
            end
            S_D_FIXN:
            begin
                ram_we        = 1'b1;
                ram_waddr     = n_reg[PAGE_W-1:0];
                ram_wdata     = ram_rdata;
                ram_wdata.prv = p_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        result.status     = status_reg;
        result.block_page = bpage_reg;
        result.free_total = free_total;
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_DONE;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        o_reg      <= o_next;
        want_reg   <= want_next;
        blk_reg    <= blk_next;
        cur_reg    <= cur_next;
        end_reg    <= end_next;
        pord_reg   <= pord_next;
        ppg_reg    <= ppg_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        f_reg      <= f_next;
        status_reg <= status_next;
        bpage_reg  <= bpage_next;
    end

`ifndef SYNTHESIS
    // A result strobe lasts one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");

    // An accepted transaction makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after accept");

    // Only a successful allocate reports a block page.
    a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> result.block_page == '0)
        else $error("block page set on a failed transaction");

    // The memory is never written while waiting for a transaction.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !ram_we) else $error("memory write while idle");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the buddy page allocator.
// Depends on bpa_pkg and buddy_page_allocator; a local allocator model predicts each result.
module tb;
    import bpa_pkg::*;

    localparam int NPG   = 4096;
    localparam int NORD  = 11;
    localparam int LIMIT = 4000000;

    logic     clk;
    logic     rst_n;
    logic     start;
    bpa_req_t request;
    logic     busy;
    logic     done;
    bpa_rsp_t result;

    buddy_page_allocator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Allocator model state.
    bit          is_head  [NPG];
    int unsigned head_ord [NPG];
    int unsigned nxt_pg   [NPG];
    int unsigned prv_pg   [NPG];
    int unsigned front_pg [NORD];
    int unsigned blk_cnt  [NORD];
    int unsigned pages_free;

    bpa_rsp_t    expected_rsp[$];
    int unsigned live_blocks[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    longint      cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int unsigned size_order(input int unsigned cnt);
        int unsigned o;
        o = 0;
        while (o < 16 && (32'd1 << o) < cnt)
            o++;
        return o;
    endfunction

    function automatic void list_push(input int unsigned o, input int unsigned pg);
        int unsigned f;
        f = front_pg[o];
        nxt_pg[pg] = f;
        prv_pg[pg] = NPG;
        if (f < NPG)
            prv_pg[f] = pg;
        front_pg[o] = pg;
        blk_cnt[o]++;
        is_head[pg] = 1'b1;
        head_ord[pg] = o;
        pages_free += 32'd1 << o;
    endfunction

    function automatic void list_drop(input int unsigned o, input int unsigned pg);
        int unsigned n;
        int unsigned p;
        n = nxt_pg[pg];
        p = prv_pg[pg];
        if (p < NPG)
            nxt_pg[p] = n;
        else
            front_pg[o] = n;
        if (n < NPG)
            prv_pg[n] = p;
        blk_cnt[o]--;
        is_head[pg] = 1'b0;
        pages_free -= 32'd1 << o;
    endfunction

    // Computes the result of one transaction and updates the model.
    function automatic bpa_rsp_t allocator_step(input bpa_req_t rq);
        bpa_rsp_t    r;
        int unsigned pg;
        int unsigned cnt;
        int unsigned want;
        int unsigned o;
        int unsigned blk;
        int unsigned cur;
        int unsigned bud;
        int unsigned last;
        r = '0;
        pg = rq.page;
        cnt = rq.count;
        if (rq.operation == OP_ALLOC)
        begin
            want = size_order(cnt);
            o = want;
            while (o < NORD && blk_cnt[o] == 0)
                o++;
            if (want >= NORD || o >= NORD)
                r.status = ST_NOSPACE;
            else
            begin
                blk = front_pg[o];
                list_drop(o, blk);
                while (o > want)
                begin
                    o--;
                    list_push(o, blk + (32'd1 << o));
                end
                head_ord[blk] = want;
                r.block_page = blk[11:0];
                live_blocks.push_back(blk | (want << 16));
            end
        end
        else if (rq.operation == OP_FREE)
        begin
            o = size_order(cnt);
            if (o >= NORD || pg + (32'd1 << o) > NPG)
                r.status = ST_REJECT;
            else if (!is_head[pg])
            begin
                cur = pg;
                while (o + 1 < NORD)
                begin
                    bud = cur ^ (32'd1 << o);
                    if (bud >= NPG || !is_head[bud] || head_ord[bud] != o)
                        break;
                    list_drop(o, bud);
                    if (bud < cur)
                        cur = bud;
                    o++;
                end
                list_push(o, cur);
            end
        end
        else if (rq.operation == OP_ADD)
        begin
            last = pg + cnt;
            if (last > NPG)
                last = NPG;
            cur = pg;
            while (cur < last)
            begin
                o = NORD - 1;
                while (o > 0 && ((32'd1 << o) > last - cur || (cur & ((32'd1 << o) - 1)) != 0))
                    o--;
                if (!is_head[cur])
                    list_push(o, cur);
                cur += 32'd1 << o;
            end
        end
        r.free_total = pages_free[12:0];
        return r;
    endfunction

    // Result checker: compare each strobed transaction with the oldest expectation.
    always @(posedge clk)
    begin
        bpa_rsp_t e;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                n_checked++;
                if (result.status !== e.status || result.block_page !== e.block_page ||
                    result.free_total !== e.free_total)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, result);
                    errors++;
                end
            end
        end
    end

    // Sends one transaction after a random gap and records its expected result.
    task automatic send_op(input op_t op, input int unsigned pg, input int unsigned cnt,
                           input bit no_gap = 1'b0);
        int gap;
        bpa_req_t rq;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (no_gap)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            request <= bpa_req_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        rq.operation = op;
        rq.page = pg[11:0];
        rq.count = cnt[12:0];
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_rsp.push_back(allocator_step(rq));
        n_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, rejects, idle operation and clipping.
    task automatic test_directed();
        send_op(OP_ALLOC, 0, 1);
        send_op(OP_FREE, 4095, 1);
        send_op(OP_FREE, 4095, 1);
        send_op(OP_FREE, 0, 4096);
        send_op(OP_FREE, 4094, 4);
        send_op(OP_ALLOC, 4095, 8191);
        send_op(OP_ADD, 3, 0);
        send_op(OP_ADD, 3, 29);
        send_op(OP_ADD, 4000, 8191);
        send_op(OP_ADD, 3, 29);
        send_op(OP_NONE, 4095, 8191);
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_ALLOC, 0, 1024);
        send_op(OP_ALLOC, 0, 1025);
        send_op(OP_ADD, 0, 4096, 1'b1);
        send_op(OP_ALLOC, 0, 1024, 1'b1);
        send_op(OP_ALLOC, 0, 1024);
        send_op(OP_ALLOC, 2730, 5);
        send_op(OP_FREE, 2048, 1024);
        send_op(OP_FREE, 1024, 2048);
        send_op(OP_FREE, 0, 2049);
        send_op(OP_FREE, 0, 1024);
        send_op(OP_ALLOC, 0, 3);
        wait_drained();
    endtask

    // Mostly alloc/free of live blocks with random sizes, plus noise.
    task automatic test_random(input int unsigned n);
        int unsigned k;
        int unsigned pick;
        int unsigned idx;
        int unsigned blk;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_op(OP_ALLOC, $urandom, ($urandom_range(0, 7) == 0) ?
                        $urandom_range(0, 8191) : $urandom_range(0, 64));
            else if (pick < 85 && live_blocks.size() != 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                blk = live_blocks[idx];
                live_blocks.delete(idx);
                send_op(OP_FREE, blk & 16'hFFFF, 32'd1 << (blk >> 16));
            end
            else if (pick < 92)
                send_op(OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 300));
            else if (pick < 98)
                send_op(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 8191));
            else
                send_op(OP_NONE, $urandom, $urandom);
            if (k == n / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        cycles = 0;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        for (int i = 0; i < NPG; i++)
        begin
            is_head[i] = 1'b0;
            head_ord[i] = 0;
        end
        for (int i = 0; i < NORD; i++)
        begin
            front_pg[i] = NPG;
            blk_cnt[i] = 0;
        end
        pages_free = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1300);
        repeat (100) @(posedge clk);
        $display("Sent %0d transactions (alloc, free, add region, rejects), checked %0d results.",
                 n_sent, n_checked);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- buddy_page_allocator.f -----
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_lists.sv
rtl/buddy_page_allocator.sv
tb/tb.sv
